// ----- rtl/crat_pkg.sv -----
// Shared constants, codes and types of the checked rational ALU.
`timescale 1ns / 1ps
`default_nettype none
package crat_pkg;

    localparam int WIDTH_DEF = 64;
    localparam int FIELD_W   = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_GCD
    } t_uop;

    typedef struct packed {
        logic go;
        t_uop op;
    } t_unit_req;

endpackage
`default_nettype wire

// ----- rtl/crat_if.sv -----
// Request and result channel interfaces of the checked rational ALU.
`timescale 1ns / 1ps
`default_nettype none
interface crat_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] a_num;
    logic [63:0] a_den;
    logic [63:0] b_num;
    logic [63:0] b_den;

    modport source(output valid, output operation, output a_num, output a_den,
                   output b_num, output b_den, input ready);
    modport sink(input valid, input operation, input a_num, input a_den,
                 input b_num, input b_den, output ready);
endinterface

interface crat_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;

    modport source(output valid, output res_num, output res_den, output order,
                   output status, input ready);
    modport sink(input valid, input res_num, input res_den, input order,
                 input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/crat_unit.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, binary GCD.
`timescale 1ns / 1ps
`default_nettype none
module crat_unit #(
    parameter int W = crat_pkg::WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire crat_pkg::t_unit_req  i_req,
    input  wire logic [2*W-1:0]       i_x,
    input  wire logic [W-1:0]         i_y,
    output logic                      o_done,
    output logic [2*W-1:0]            o_q,
    output logic [W-1:0]              o_r
);
    localparam int CW = $clog2(2*W+1);
    localparam int KW = $clog2(W);

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_GCD} t_ustate;

    t_ustate        r_state;
    logic [2*W-1:0] r_acc;
    logic [2*W-1:0] r_sh;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [CW-1:0]  r_cnt;
    logic [KW-1:0]  r_k;
    logic           r_done;

    logic [2*W-1:0] mul_sum;
    logic [W:0]     div_rs;
    logic           div_ge;
    logic [W:0]     div_diff;
    logic [W-1:0]   gcd_res;
    logic           hi_zero;

    assign mul_sum  = r_acc + r_sh;
    assign div_rs   = {r_a, r_sh[2*W-1]};
    assign div_ge   = div_rs >= {1'b0, r_b};
    assign div_diff = div_rs - {1'b0, r_b};
    assign gcd_res  = ((r_a == '0) ? r_b : r_a) << r_k;
    assign hi_zero  = i_x[2*W-1:W] == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.go) begin
                        r_acc <= '0;
                        r_b   <= i_y;
                        unique case (i_req.op)
                            crat_pkg::UOP_MUL: begin
                                r_sh    <= {{W{1'b0}}, i_x[W-1:0]};
                                r_cnt   <= CW'(W);
                                r_state <= U_MUL;
                            end
                            crat_pkg::UOP_DIV: begin
                                // skip the empty upper half of a narrow dividend
                                r_sh    <= hi_zero ? {i_x[W-1:0], {W{1'b0}}} : i_x;
                                r_cnt   <= hi_zero ? CW'(W) : CW'(2*W);
                                r_a     <= '0;
                                r_state <= U_DIV;
                            end
                            default: begin
                                r_a     <= i_x[W-1:0];
                                r_k     <= '0;
                                r_state <= U_GCD;
                            end
                        endcase
                    end
                end
                U_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= mul_sum;
                    end
                    r_sh  <= r_sh << 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                U_DIV: begin
                    r_acc <= {r_acc[2*W-2:0], div_ge};
                    r_a   <= div_ge ? div_diff[W-1:0] : div_rs[W-1:0];
                    r_sh  <= r_sh << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                U_GCD: begin
                    priority if (r_a == '0 || r_b == '0) begin
                        r_acc   <= {{W{1'b0}}, gcd_res};
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= r_a - r_b;
                    end else begin
                        r_b <= r_b - r_a;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_acc;
    assign o_r    = r_a;

endmodule
`default_nettype wire

// ----- rtl/checked_rational_alu.sv -----
// Top level of the checked rational ALU: sequencer around one shared unit.
// Usage
//   i_req carries one request: an operation (add, subtract, multiply,
//   divide, compare) and two non-negative rationals a_num/a_den, b_num/b_den.
//   Only the low WIDTH bits of each part are used. o_res returns one result
//   per request: numerator, denominator, compare order and status.
//   Both channels move a request or result when valid and ready are high.
// Sequencing
//   One request at a time; i_req.ready is high only while the sequencer idles.
//   All products, quotients and GCDs run on one shared iterative unit, one
//   step at a time. A result that fits unreduced is emitted directly; one
//   that does not is reduced to lowest terms and recomputed first.
// Reset and stalls
//   Synchronous active-low reset returns the sequencer to idle and drops any
//   pending result. A finished result waits in the output register while
//   o_res.ready is low; the next request is accepted meanwhile and is held
//   at its end until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module checked_rational_alu #(
    parameter int WIDTH = crat_pkg::WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crat_req_if.sink    i_req,
    crat_res_if.source  o_res
);
    localparam int W = WIDTH;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_XM, S_YM, S_SUM, S_DM, S_NM, S_AFIT, S_MFIT,
        S_GA, S_AN, S_AD, S_GB, S_BN, S_BD,
        S_G, S_T1, S_T2, S_R, S_G2, S_Q, S_T3,
        S_G1, S_AN1, S_BD1, S_G2M, S_BN2, S_AD2,
        S_EMIT
    } t_state;

    t_state         r_state;
    logic [2:0]     r_op;
    logic [W-1:0]   r_an, r_ad, r_bn, r_bd, r_g, r_t1;
    logic [2*W-1:0] r_x, r_y, r_n, r_d;
    logic           r_cy;
    logic           r_red;
    logic           r_wait;
    // staged result
    logic [W-1:0]   r_rnum, r_rden;
    logic [1:0]     r_rord, r_rst;
    // output register
    logic           r_ovalid;
    logic [63:0]    r_onum, r_oden;
    logic [1:0]     r_oord, r_ost;

    crat_pkg::t_unit_req u_req;
    logic [2*W-1:0]      u_x;
    logic [W-1:0]        u_y;
    logic                u_done;
    logic [2*W-1:0]      u_q;
    logic [W-1:0]        u_r;
    logic                u_run;

    logic [2*W:0]   sum_w;
    logic [2*W-1:0] diff_w;
    logic           n_fits, d_fits, is_addsub;

    assign sum_w     = {1'b0, r_x} + {1'b0, r_y};
    assign diff_w    = r_x - r_y;
    assign n_fits    = r_n[2*W-1:W] == '0;
    assign d_fits    = r_d[2*W-1:W] == '0;
    assign is_addsub = (r_op == crat_pkg::OP_ADD) || (r_op == crat_pkg::OP_SUB);

    // Operand selection for the shared unit, one pairing per sequencer step.
    always_comb begin
        u_run    = 1'b1;
        u_req.op = crat_pkg::UOP_DIV;
        u_x      = '0;
        u_y      = '0;
        unique case (r_state)
            S_XM: begin
                u_req.op = crat_pkg::UOP_MUL;
                u_x      = {{W{1'b0}}, r_an};
                u_y      = r_red ? r_t1 : r_bd;
            end
            S_YM: begin
                u_req.op = crat_pkg::UOP_MUL;
                u_x      = {{W{1'b0}}, r_bn};
                u_y      = r_ad;
            end
            S_DM: begin
                u_req.op = crat_pkg::UOP_MUL;
                u_x      = {{W{1'b0}}, r_ad};
                u_y      = r_bd;
            end
            S_NM: begin
                u_req.op = crat_pkg::UOP_MUL;
                u_x      = {{W{1'b0}}, r_an};
                u_y      = r_bn;
            end
            S_GA: begin
                u_req.op = crat_pkg::UOP_GCD;
                u_x      = {{W{1'b0}}, r_an};
                u_y      = r_ad;
            end
            S_GB: begin
                u_req.op = crat_pkg::UOP_GCD;
                u_x      = {{W{1'b0}}, r_bn};
                u_y      = r_bd;
            end
            S_G: begin
                u_req.op = crat_pkg::UOP_GCD;
                u_x      = {{W{1'b0}}, r_ad};
                u_y      = r_bd;
            end
            S_G1: begin
                u_req.op = crat_pkg::UOP_GCD;
                u_x      = {{W{1'b0}}, r_an};
                u_y      = r_bd;
            end
            S_G2M: begin
                u_req.op = crat_pkg::UOP_GCD;
                u_x      = {{W{1'b0}}, r_bn};
                u_y      = r_ad;
            end
            S_G2: begin
                u_req.op = crat_pkg::UOP_GCD;
                u_x      = {{W{1'b0}}, r_g};
                u_y      = r_t1;
            end
            S_AN, S_AN1: begin
                u_x = {{W{1'b0}}, r_an};
                u_y = r_g;
            end
            S_AD, S_AD2, S_T2: begin
                u_x = {{W{1'b0}}, r_ad};
                u_y = r_g;
            end
            S_BN, S_BN2: begin
                u_x = {{W{1'b0}}, r_bn};
                u_y = r_g;
            end
            S_BD, S_BD1, S_T1, S_T3: begin
                u_x = {{W{1'b0}}, r_bd};
                u_y = r_g;
            end
            S_R, S_Q: begin
                u_x = r_n;
                u_y = r_g;
            end
            default: u_run = 1'b0;
        endcase
        u_req.go = u_run && !r_wait;
    end

    crat_unit #(.W(W)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_x     (u_x),
        .i_y     (u_y),
        .o_done  (u_done),
        .o_q     (u_q),
        .o_r     (u_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (u_req.go) begin
                r_wait <= 1'b1;
            end
            if (u_done) begin
                r_wait <= 1'b0;
            end
            // drop the result once taken
            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.operation;
                        r_an    <= i_req.a_num[W-1:0];
                        r_ad    <= i_req.a_den[W-1:0];
                        r_bn    <= i_req.b_num[W-1:0];
                        r_bd    <= i_req.b_den[W-1:0];
                        r_red   <= 1'b0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (r_op > crat_pkg::OP_CMP || r_ad == '0 || r_bd == '0
                                 || (r_op == crat_pkg::OP_DIV && r_bn == '0)) begin
                        r_rnum  <= '0;
                        r_rden  <= '0;
                        r_rord  <= crat_pkg::ORD_LT;
                        r_rst   <= crat_pkg::ST_INV;
                        r_state <= S_EMIT;
                    end else if (r_op == crat_pkg::OP_DIV) begin
                        // divide is multiply by the swapped second operand
                        r_bn    <= r_bd;
                        r_bd    <= r_bn;
                        r_state <= S_NM;
                    end else if (r_op == crat_pkg::OP_MUL) begin
                        r_state <= S_NM;
                    end else begin
                        r_state <= S_XM;
                    end
                end
                S_XM: begin
                    if (u_done) begin
                        r_x     <= u_q;
                        r_state <= S_YM;
                    end
                end
                S_YM: begin
                    if (u_done) begin
                        r_y <= u_q;
                        if (r_op == crat_pkg::OP_CMP) begin
                            r_rnum  <= '0;
                            r_rden  <= W'(1);
                            r_rst   <= crat_pkg::ST_OK;
                            r_rord  <= (r_x < u_q) ? crat_pkg::ORD_LT :
                                       (r_x == u_q) ? crat_pkg::ORD_EQ : crat_pkg::ORD_GT;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    priority if (!r_red && r_op == crat_pkg::OP_SUB && r_x < r_y) begin
                        r_rnum  <= '0;
                        r_rden  <= '0;
                        r_rord  <= crat_pkg::ORD_LT;
                        r_rst   <= crat_pkg::ST_INV;
                        r_state <= S_EMIT;
                    end else if (r_red && r_op == crat_pkg::OP_ADD && sum_w[2*W]) begin
                        r_rnum  <= '0;
                        r_rden  <= '0;
                        r_rord  <= crat_pkg::ORD_LT;
                        r_rst   <= crat_pkg::ST_OVF;
                        r_state <= S_EMIT;
                    end else begin
                        r_n     <= (r_op == crat_pkg::OP_SUB) ? diff_w : sum_w[2*W-1:0];
                        r_cy    <= (r_op == crat_pkg::OP_ADD) && sum_w[2*W];
                        r_state <= r_red ? S_R : S_DM;
                    end
                end
                S_NM: begin
                    if (u_done) begin
                        r_n     <= u_q;
                        r_state <= S_DM;
                    end
                end
                S_DM: begin
                    if (u_done) begin
                        r_d     <= u_q;
                        r_state <= (is_addsub && !r_red) ? S_AFIT : S_MFIT;
                    end
                end
                S_AFIT: begin
                    if (!r_cy && n_fits && d_fits) begin
                        r_rnum  <= r_n[W-1:0];
                        r_rden  <= r_d[W-1:0];
                        r_rord  <= crat_pkg::ORD_LT;
                        r_rst   <= crat_pkg::ST_OK;
                        r_state <= S_EMIT;
                    end else begin
                        r_red   <= 1'b1;
                        r_state <= S_GA;
                    end
                end
                S_MFIT: begin
                    priority if (n_fits && d_fits) begin
                        r_rnum  <= r_n[W-1:0];
                        r_rden  <= r_d[W-1:0];
                        r_rord  <= crat_pkg::ORD_LT;
                        r_rst   <= crat_pkg::ST_OK;
                        r_state <= S_EMIT;
                    end else if (r_red) begin
                        r_rnum  <= '0;
                        r_rden  <= '0;
                        r_rord  <= crat_pkg::ORD_LT;
                        r_rst   <= crat_pkg::ST_OVF;
                        r_state <= S_EMIT;
                    end else begin
                        r_red   <= 1'b1;
                        r_state <= S_GA;
                    end
                end
                // reduce both operands to lowest terms
                S_GA:  if (u_done) begin r_g  <= u_q[W-1:0]; r_state <= S_AN; end
                S_AN:  if (u_done) begin r_an <= u_q[W-1:0]; r_state <= S_AD; end
                S_AD:  if (u_done) begin r_ad <= u_q[W-1:0]; r_state <= S_GB; end
                S_GB:  if (u_done) begin r_g  <= u_q[W-1:0]; r_state <= S_BN; end
                S_BN:  if (u_done) begin r_bn <= u_q[W-1:0]; r_state <= S_BD; end
                S_BD: begin
                    if (u_done) begin
                        r_bd    <= u_q[W-1:0];
                        r_state <= is_addsub ? S_G : S_G1;
                    end
                end
                // add and subtract over the lcm of the denominators
                S_G:   if (u_done) begin r_g  <= u_q[W-1:0]; r_state <= S_T1; end
                S_T1:  if (u_done) begin r_t1 <= u_q[W-1:0]; r_state <= S_T2; end
                S_T2:  if (u_done) begin r_ad <= u_q[W-1:0]; r_state <= S_XM; end
                S_R:   if (u_done) begin r_t1 <= u_r;        r_state <= S_G2; end
                S_G2:  if (u_done) begin r_g  <= u_q[W-1:0]; r_state <= S_Q; end
                S_Q:   if (u_done) begin r_n  <= u_q;        r_state <= S_T3; end
                S_T3:  if (u_done) begin r_bd <= u_q[W-1:0]; r_state <= S_DM; end
                // multiply: cancel across the two operands
                S_G1:  if (u_done) begin r_g  <= u_q[W-1:0]; r_state <= S_AN1; end
                S_AN1: if (u_done) begin r_an <= u_q[W-1:0]; r_state <= S_BD1; end
                S_BD1: if (u_done) begin r_bd <= u_q[W-1:0]; r_state <= S_G2M; end
                S_G2M: if (u_done) begin r_g  <= u_q[W-1:0]; r_state <= S_BN2; end
                S_BN2: if (u_done) begin r_bn <= u_q[W-1:0]; r_state <= S_AD2; end
                S_AD2: if (u_done) begin r_ad <= u_q[W-1:0]; r_state <= S_NM; end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_onum   <= 64'(r_rnum);
                        r_oden   <= 64'(r_rden);
                        r_oord   <= r_rord;
                        r_ost    <= r_rst;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready   = r_state == S_IDLE;
    assign o_res.valid   = r_ovalid;
    assign o_res.res_num = r_onum;
    assign o_res.res_den = r_oden;
    assign o_res.order   = r_oord;
    assign o_res.status  = r_ost;

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> r_wait)
        else $error("unit finished without an outstanding step");

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_wait)
        else $error("request accepted while the unit is busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != crat_pkg::ST_OK) |->
        (o_res.res_num == 64'd0 && o_res.res_den == 64'd0
         && o_res.order == crat_pkg::ORD_LT))
        else $error("error result carries a value");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_ovalid) |=> (o_res.valid && r_state == S_IDLE))
        else $error("finished result not loaded into the output register");

endmodule
`default_nettype wire
